// ===== src/alc_pkg.sv =====
// shared types and codes for the array list with cursor
`timescale 1ns / 1ps

package alc_pkg;

    // command codes on func
    typedef enum logic [3:0] {
        FN_INSERT = 4'd0,
        FN_APPEND = 4'd1,
        FN_ERASE  = 4'd2,
        FN_CLEAR  = 4'd3,
        FN_START  = 4'd4,
        FN_END    = 4'd5,
        FN_NEXT   = 4'd6,
        FN_PREV   = 4'd7,
        FN_MOVE   = 4'd8,
        FN_GET    = 4'd9
    } func_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_FULL         = 2'd1,
        ST_NO_ELEMENT   = 2'd2,
        ST_OUT_OF_RANGE = 2'd3
    } status_t;

    // broadcast to every cell: which shift or write happens this cycle
    typedef struct packed {
        logic ins;
        logic app;
        logic ers;
    } cell_ctrl_t;

    // entries per group of the registered read tree
    localparam int GROUP_SIZE = 32;

endpackage

// ===== src/alc_cell.sv =====
// one list entry: holds a value and shifts with its neighbors
`timescale 1ns / 1ps

module alc_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int CNT_W      = 7,
    parameter int INDEX      = 0
) (
    input  logic                  clk,
    input  alc_pkg::cell_ctrl_t   ctrl,
    input  logic [CNT_W-1:0]      cursor,
    input  logic [CNT_W-1:0]      count,
    input  logic [DATA_WIDTH-1:0] value,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic [DATA_WIDTH-1:0] data,
    output logic [DATA_WIDTH-1:0] masked
);

    localparam logic [CNT_W-1:0] IDX    = INDEX[CNT_W-1:0];
    localparam logic [CNT_W:0]   IDX_P1 = (CNT_W + 1)'(INDEX + 1);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  load;

    always_comb
    begin
        load      = 1'b0;
        data_next = data_reg;
        priority if (ctrl.ins && IDX == cursor)
        begin
            load      = 1'b1;
            data_next = value;
        end
        else if (ctrl.ins && IDX > cursor && IDX <= count)
        begin
            load      = 1'b1;
            data_next = left_data;
        end
        else if (ctrl.app && IDX == count)
        begin
            load      = 1'b1;
            data_next = value;
        end
        else if (ctrl.ers && IDX >= cursor && IDX_P1 < {1'b0, count})
        begin
            load      = 1'b1;
            data_next = right_data;
        end
        else
        begin
            // entry holds its value
            load      = 1'b0;
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign data   = data_reg;
    assign masked = (IDX == cursor) ? data_reg : '0;

endmodule

// ===== src/alc_read_tree.sv =====
// registered or-tree that picks the entry under the cursor
`timescale 1ns / 1ps

module alc_read_tree #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  capture,
    input  logic [DATA_WIDTH-1:0] lane [CAPACITY],
    output logic [DATA_WIDTH-1:0] result
);

    localparam int NUM_GROUPS = (CAPACITY + alc_pkg::GROUP_SIZE - 1) / alc_pkg::GROUP_SIZE;

    logic [DATA_WIDTH-1:0] group_reg  [NUM_GROUPS];
    logic [DATA_WIDTH-1:0] group_next [NUM_GROUPS];

    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            group_next[g] = '0;
            for (int j = 0; j < alc_pkg::GROUP_SIZE; j++)
            begin
                if (g * alc_pkg::GROUP_SIZE + j < CAPACITY)
                begin
                    group_next[g] = group_next[g] | lane[g * alc_pkg::GROUP_SIZE + j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            for (int g = 0; g < NUM_GROUPS; g++)
            begin
                group_reg[g] <= group_next[g];
            end
        end
    end

    always_comb
    begin
        result = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            result = result | group_reg[g];
        end
    end

endmodule

// ===== src/array_list_with_cursor_unit.sv =====
// top level of the array list with cursor
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY values with a cursor. A command transaction is
// taken when start is high and busy is low; its result appears on the result
// ports for exactly one cycle with done high, and must be taken then, since
// the receiver cannot hold it off. busy is high in the cycle after each
// accepted command, and no command is taken while busy; a new command may be
// accepted in the same cycle that the previous result is shown. The read path
// is registered: the entry under the cursor is captured by a registered
// or-tree over the cells, then by the result registers. Each entry has its
// own cell; insert and erase shift the cells from the cursor on in parallel
// in the cycle the command is accepted. No clearing pass is needed after reset.

module array_list_with_cursor_unit #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [3:0]                           func,
    input  logic [DATA_WIDTH-1:0]                value,
    input  logic [$clog2(CAPACITY + 1)-1:0]      position,
    output logic                                 done,
    output logic [1:0]                           status,
    output logic [$clog2(CAPACITY + 1)-1:0]      inserted_at,
    output logic [DATA_WIDTH-1:0]                read_value,
    output logic [$clog2(CAPACITY + 1)-1:0]      length,
    output logic [$clog2(CAPACITY + 1)-1:0]      cursor
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CAPACITY[CNT_W-1:0];

    // list state
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [CNT_W-1:0] cursor_reg, cursor_next;

    // command in flight through the read tree
    logic                 pend_reg;
    alc_pkg::status_t     pend_status_reg, pend_status_next;
    logic [CNT_W-1:0]     pend_ins_reg,    pend_ins_next;
    logic                 pend_read_reg,   pend_read_next;

    // result registers
    logic                  done_reg;
    alc_pkg::status_t      status_out_reg;
    logic [CNT_W-1:0]      ins_out_reg;
    logic [DATA_WIDTH-1:0] read_out_reg;
    logic [CNT_W-1:0]      length_out_reg;
    logic [CNT_W-1:0]      cursor_out_reg;

    logic                  accept;
    logic                  full;
    logic                  at_end;
    alc_pkg::cell_ctrl_t   ctrl_raw;
    alc_pkg::cell_ctrl_t   ctrl;

    logic [DATA_WIDTH-1:0] cell_data   [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_masked [CAPACITY];
    logic [DATA_WIDTH-1:0] tree_result;

    assign accept = start && !pend_reg;
    assign full   = (count_reg == CAP_CNT);
    // cursor never exceeds length, so equality means no element under it
    assign at_end = (cursor_reg >= count_reg);

    // command decode against the state before the transaction
    always_comb
    begin
        count_next       = count_reg;
        cursor_next      = cursor_reg;
        pend_status_next = alc_pkg::ST_OK;
        pend_ins_next    = '0;
        pend_read_next   = 1'b0;
        ctrl_raw         = '0;
        unique case (alc_pkg::func_t'(func))
            alc_pkg::FN_INSERT:
            begin
                if (full)
                begin
                    pend_status_next = alc_pkg::ST_FULL;
                end
                else
                begin
                    ctrl_raw.ins  = 1'b1;
                    pend_ins_next = cursor_reg;
                    count_next    = count_reg + 1'b1;
                end
            end
            alc_pkg::FN_APPEND:
            begin
                if (full)
                begin
                    pend_status_next = alc_pkg::ST_FULL;
                end
                else
                begin
                    ctrl_raw.app = 1'b1;
                    count_next   = count_reg + 1'b1;
                end
            end
            alc_pkg::FN_ERASE:
            begin
                if (at_end)
                begin
                    pend_status_next = alc_pkg::ST_NO_ELEMENT;
                end
                else
                begin
                    ctrl_raw.ers   = 1'b1;
                    pend_read_next = 1'b1;
                    count_next     = count_reg - 1'b1;
                end
            end
            alc_pkg::FN_CLEAR:
            begin
                count_next  = '0;
                cursor_next = '0;
            end
            alc_pkg::FN_START:
            begin
                cursor_next = '0;
            end
            alc_pkg::FN_END:
            begin
                cursor_next = count_reg;
            end
            alc_pkg::FN_NEXT:
            begin
                if (!at_end)
                begin
                    cursor_next = cursor_reg + 1'b1;
                end
            end
            alc_pkg::FN_PREV:
            begin
                if (cursor_reg != '0)
                begin
                    cursor_next = cursor_reg - 1'b1;
                end
            end
            alc_pkg::FN_MOVE:
            begin
                if (position > count_reg)
                begin
                    pend_status_next = alc_pkg::ST_OUT_OF_RANGE;
                end
                else
                begin
                    cursor_next = position;
                end
            end
            alc_pkg::FN_GET:
            begin
                if (at_end)
                begin
                    pend_status_next = alc_pkg::ST_NO_ELEMENT;
                end
                else
                begin
                    pend_read_next = 1'b1;
                end
            end
            default:
            begin
                // unused codes leave the list and the cursor alone
            end
        endcase
    end

    assign ctrl = accept ? ctrl_raw : '0;

    // state and pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            cursor_reg <= '0;
            pend_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            pend_reg <= accept;
            done_reg <= pend_reg;
            if (accept)
            begin
                count_reg  <= count_next;
                cursor_reg <= cursor_next;
            end
        end
    end

    // payload of the transaction in flight and of the result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_status_reg <= pend_status_next;
            pend_ins_reg    <= pend_ins_next;
            pend_read_reg   <= pend_read_next;
        end
        if (pend_reg)
        begin
            status_out_reg <= pend_status_reg;
            ins_out_reg    <= pend_ins_reg;
            read_out_reg   <= pend_read_reg ? tree_result : '0;
            length_out_reg <= count_reg;
            cursor_out_reg <= cursor_reg;
        end
    end

    // row of cells, each handing its value to each neighbor it has
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_in;
        logic [DATA_WIDTH-1:0] right_in;

        if (i == 0)
        begin : g_first
            assign left_in = '0;
        end
        else
        begin : g_left
            assign left_in = cell_data[i - 1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_in = '0;
        end
        else
        begin : g_right
            assign right_in = cell_data[i + 1];
        end

        alc_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .INDEX      (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .cursor     (cursor_reg),
            .count      (count_reg),
            .value      (value),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[i]),
            .masked     (cell_masked[i])
        );
    end

    // captures the entry under the cursor before any shift lands
    alc_read_tree #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_read_tree (
        .clk     (clk),
        .capture (accept),
        .lane    (cell_masked),
        .result  (tree_result)
    );

    assign busy        = pend_reg;
    assign done        = done_reg;
    assign status      = status_out_reg;
    assign inserted_at = ins_out_reg;
    assign read_value  = read_out_reg;
    assign length      = length_out_reg;
    assign cursor      = cursor_out_reg;

endmodule

// ===== src/alc_checker.sv =====
// port-level checks for the array list with cursor, bound to the top level
`timescale 1ns / 1ps

module alc_checker #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              done,
    input logic [1:0]                        status,
    input logic [$clog2(CAPACITY + 1)-1:0]   inserted_at,
    input logic [DATA_WIDTH-1:0]             read_value,
    input logic [$clog2(CAPACITY + 1)-1:0]   length,
    input logic [$clog2(CAPACITY + 1)-1:0]   cursor
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CAPACITY[CNT_W-1:0];

    // an accepted transaction keeps the unit busy for the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    // every busy cycle is followed by a result with done high
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
        else $error("result missing after busy cycle");

    // cursor stays within the list and the list within capacity
    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (cursor <= length) && (length <= CAP_CNT))
        else $error("cursor or length out of bounds");

    // a failed command reports neither an index nor a value
    a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != alc_pkg::ST_OK |-> inserted_at == '0 && read_value == '0)
        else $error("failed command reported data");

endmodule

bind array_list_with_cursor_unit alc_checker #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
) u_alc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .inserted_at (inserted_at),
    .read_value  (read_value),
    .length      (length),
    .cursor      (cursor)
);
